/* rtl/core/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg: shared constants and types for the masked byte pattern scanner
// Register index codes, window geometry and the structs passed between the
// configuration, window and tracking stages.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int WINDOW_DEPTH      = 16;
  localparam int OFFSET_BITS       = 32;

  localparam int WIN_IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int LEN_W      = 5;
  localparam int SEEN_W     = 32;
  localparam int COUNT_W    = 16;
  localparam int ADDR_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // usable pattern length is capped by both the pattern store and the window
  localparam int USED_MAX = (MAX_PATTERN_BYTES < WINDOW_DEPTH) ? MAX_PATTERN_BYTES
                                                                : WINDOW_DEPTH;
  // offset bits that can be non-zero after masking the 32-bit byte count
  localparam int OFF_USED = (OFFSET_BITS < SEEN_W) ? OFFSET_BITS : SEEN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR    = 3'd5;

  typedef struct packed {
    logic [15:0][7:0]     pattern;
    logic [15:0]          care;
    logic [LEN_W-1:0]     used_len;
    logic [COUNT_W-1:0]   max_matches;
    logic [ADDR_W-1:0]    base_addr;
  } cfg_t;

  // one byte leaving the input register towards the window
  typedef struct packed {
    logic       adv;
    logic [7:0] data;
    logic       last;
  } step_t;

endpackage

/* rtl/core/mbps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mbps_cfg_regs: configuration register file
// Holds pattern, care mask, clamped pattern length, match limit and base.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mbps_pkg::cfg_t                cfg_o
);
  import mbps_pkg::*;

  cfg_t             cfg_q;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_clamped;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // zero means one byte, anything too long is cut to the usable maximum
  always_comb begin
    len_raw = cfg_data_i[LEN_W-1:0];
    if (len_raw == '0) begin
      len_clamped = LEN_W'(1);
    end else if (len_raw > LEN_W'(USED_MAX)) begin
      len_clamped = LEN_W'(USED_MAX);
    end else begin
      len_clamped = len_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern     <= '0;
      cfg_q.care        <= '1;
      cfg_q.used_len    <= LEN_W'(1);
      cfg_q.max_matches <= '0;
      cfg_q.base_addr   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PATTERN_LOW:  cfg_q.pattern[7:0]  <= cfg_data_i;
        CFG_PATTERN_HIGH: cfg_q.pattern[15:8] <= cfg_data_i;
        CFG_CARE_MASK:    cfg_q.care          <= cfg_data_i[15:0];
        CFG_PATTERN_LEN:  cfg_q.used_len      <= len_clamped;
        CFG_MAX_MATCHES:  cfg_q.max_matches   <= cfg_data_i[COUNT_W-1:0];
        CFG_BASE_ADDR:    cfg_q.base_addr     <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/mbps_window.sv */
// ----------------------------------------------------------------------------
// mbps_window: byte window and masked compare
// Shifts in each byte and compares the pattern with the newest bytes.
// ----------------------------------------------------------------------------
module mbps_window (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mbps_pkg::step_t step_i,
  input  mbps_pkg::cfg_t  cfg_i,
  output logic           win_match_o
);
  import mbps_pkg::*;

  logic [WINDOW_DEPTH-1:0][7:0] win_q;
  logic [WINDOW_DEPTH-1:0][7:0] win_d;
  logic [WINDOW_DEPTH-1:0][7:0] win_next;
  logic [LEN_W-1:0]             pos;
  logic                         match;

  // window as it stands once the incoming byte is shifted in
  always_comb begin
    win_next[0] = step_i.data;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      win_next[i] = win_q[i-1];
    end
  end

  // pattern byte j lines up with window slot len-1-j
  always_comb begin
    match = 1'b1;
    pos   = '0;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      pos = cfg_i.used_len - LEN_W'(1) - LEN_W'(j);
      if ((LEN_W'(j) < cfg_i.used_len) && cfg_i.care[j]) begin
        if (cfg_i.pattern[j] != win_next[pos[WIN_IDX_W-1:0]]) begin
          match = 1'b0;
        end
      end
    end
  end

  assign win_match_o = match;

  // drop the window at region end, otherwise advance with each byte
  always_comb begin
    win_d = win_q;
    if (step_i.adv) begin
      win_d = step_i.last ? '0 : win_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

/* rtl/core/mbps_tracker.sv */
// ----------------------------------------------------------------------------
// mbps_tracker: region counters and result register
// Counts bytes and reports, applies the match limit, forms the address.
// ----------------------------------------------------------------------------
module mbps_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s1_valid_i,
  input  logic                           s1_last_i,
  input  logic                           win_match_i,
  input  mbps_pkg::cfg_t                 cfg_i,
  output logic                           adv_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           is_match_o,
  output logic [mbps_pkg::ADDR_W-1:0]    match_address_o,
  output logic                           scan_done_o,
  output logic [mbps_pkg::COUNT_W-1:0]   match_total_o
);
  import mbps_pkg::*;

  logic [SEEN_W-1:0]  seen_q, seen_d, seen_next;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic               stop_q, stop_d, stop_next;
  logic               out_valid_q, out_valid_d;
  logic               is_match_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               done_q;
  logic [COUNT_W-1:0] total_q;
  logic [SEEN_W-1:0]  off_full;
  logic [ADDR_W-1:0]  hit_addr;
  logic               hit;
  logic               want;
  logic               out_free;
  logic               load;

  always_comb begin
    seen_next = seen_q + SEEN_W'(1);
    hit = s1_valid_i && !stop_q && win_match_i
          && (seen_next >= SEEN_W'(cfg_i.used_len));
    off_full = seen_next - SEEN_W'(cfg_i.used_len);
    hit_addr = cfg_i.base_addr + ADDR_W'(off_full[OFF_USED-1:0]);
    // saturate the report count
    cnt_next = (hit && (cnt_q != '1)) ? cnt_q + COUNT_W'(1) : cnt_q;
    stop_next = stop_q
                || (hit && (cfg_i.max_matches != '0) && (cnt_next >= cfg_i.max_matches));
    want     = hit || s1_last_i;
    out_free = !out_valid_q || !out_stall_i;
    adv_o    = s1_valid_i && (!want || out_free);
    load     = adv_o && want;
  end

  always_comb begin
    seen_d = seen_q;
    cnt_d  = cnt_q;
    stop_d = stop_q;
    if (adv_o) begin
      if (s1_last_i) begin
        seen_d = '0;
        cnt_d  = '0;
        stop_d = 1'b0;
      end else begin
        seen_d = seen_next;
        cnt_d  = cnt_next;
        stop_d = stop_next;
      end
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      cnt_q       <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_match_q <= hit;
      addr_q     <= hit ? hit_addr : '0;
      done_q     <= s1_last_i;
      total_q    <= cnt_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_match_o      = is_match_q;
  assign match_address_o = addr_q;
  assign scan_done_o     = done_q;
  assign match_total_o   = total_q;

`ifndef NO_ASSERTIONS
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (is_match_q || done_q))
    else $error("result without match or done");

  a_no_match_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !is_match_q) |-> (addr_q == '0))
    else $error("address set on a non-match result");

  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && s1_last_i) |=> (seen_q == '0 && cnt_q == '0 && !stop_q))
    else $error("region state not cleared after last byte");
`endif

endmodule

/* rtl/core/masked_byte_pattern_scanner_top.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top: wildcard byte signature search
// Streams a region byte by byte and reports masked pattern matches.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one byte per request,
//   end_of_region_i on the region's last byte. Output channel (out_valid_o /
//   out_stall_i) carries a result request for every reported match and for
//   the last byte; a match on the last byte shares one result with done.
//   Configuration (cfg_valid_i / cfg_ready_o) writes registers by index, by
//   the user only while the block is idle (unchecked); ready is always high.
// Timing:
//   One byte per cycle sustained while no result is held up by a receiver
//   stall. A byte waits in the input register; compare, counters and address
//   add then load the result register, which holds the result until the
//   receiver takes it.
// Reset and stall:
//   Reset clears the window, counters and both valid flags and loads register
//   defaults. While the receiver stalls, hold the result; bytes without a
//   result still drain, and a byte that needs the result register holds in
//   the input register and stalls the sender.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              end_of_region_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_match_o,
  output logic [mbps_pkg::ADDR_W-1:0]       match_address_o,
  output logic                              scan_done_o,
  output logic [mbps_pkg::COUNT_W-1:0]      match_total_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mbps_pkg::*;

  cfg_t       cfg;
  step_t      step;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       adv;
  logic       win_match;
  logic       accept;

  // hold the byte while it waits for the result register
  assign in_stall_o = s1_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= end_of_region_i;
    end
  end

  assign step.adv  = adv;
  assign step.data = s1_data_q;
  assign step.last = s1_last_q;

  mbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbps_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cfg_i       (cfg),
    .win_match_o (win_match)
  );

  mbps_tracker u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid_q),
    .s1_last_i       (s1_last_q),
    .win_match_i     (win_match),
    .cfg_i           (cfg),
    .adv_o           (adv),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_match_o      (is_match_o),
    .match_address_o (match_address_o),
    .scan_done_o     (scan_done_o),
    .match_total_o   (match_total_o)
  );

endmodule

/* test/masked_byte_pattern_scanner_top_tb.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top_tb: self-checking bench for the scanner
// Streams regions of bytes with injected, broken and random patterns through
// the scanner, and reprograms the registers between phases. A scoreboard
// class predicts each result from its own copy of the window, the counters
// and the registers, and checks every result request in order. Sender gaps
// and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top_tb;
  import mbps_pkg::*;

  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_BYTES  = 160;

  // indexes past the last register: the block must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam logic [ADDR_W-1:0] OFFSET_MASK =
    (OFFSET_BITS >= 64) ? '1 : ((64'd1 << OFFSET_BITS) - 64'd1);

  typedef struct packed {
    logic               is_match;
    logic [ADDR_W-1:0]  match_address;
    logic               scan_done;
    logic [COUNT_W-1:0] match_total;
  } scan_result_t;

  // Predicts scanner results byte by byte and checks them in order.
  class scan_scoreboard;
    logic [15:0][7:0]   pattern;
    logic [15:0]        care;
    logic [LEN_W-1:0]   length_reg;
    logic [COUNT_W-1:0] match_limit;
    logic [ADDR_W-1:0]  base_addr;
    logic [7:0]         window [WINDOW_DEPTH];
    logic [SEEN_W-1:0]  seen_count;
    logic [COUNT_W-1:0] reported;
    logic               stopped;
    scan_result_t       due_results [$];
    int unsigned        errors;

    function new();
      pattern     = '0;
      care        = 16'hFFFF;
      length_reg  = 5'd1;
      match_limit = '0;
      base_addr   = '0;
      errors      = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[i]) window[i] = 8'h00;
      seen_count = '0;
      reported   = '0;
      stopped    = 1'b0;
    endfunction

    function int unsigned used_len();
      int unsigned n;
      n = length_reg;
      if (n < 1) n = 1;
      if (n > USED_MAX) n = USED_MAX;
      return n;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PATTERN_LOW:  pattern[7:0]  = value;
        CFG_PATTERN_HIGH: pattern[15:8] = value;
        CFG_CARE_MASK:    care          = value[15:0];
        CFG_PATTERN_LEN:  length_reg    = value[LEN_W-1:0];
        CFG_MAX_MATCHES:  match_limit   = value[COUNT_W-1:0];
        CFG_BASE_ADDR:    base_addr     = value;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] data, logic last);
      int unsigned       len, i;
      logic              hit, ok;
      logic [ADDR_W-1:0] addr;
      logic [SEEN_W-1:0] off;
      scan_result_t      res;
      len = used_len();
      for (i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0]  = data;
      seen_count = seen_count + 1'b1;
      hit  = 1'b0;
      addr = '0;
      if (!stopped && seen_count >= len) begin
        ok = 1'b1;
        // pattern byte 0 lines up with the oldest byte of the window slice
        for (i = 0; i < len; i++)
          if (care[i] && pattern[i] != window[len-1-i]) ok = 1'b0;
        if (ok) begin
          hit  = 1'b1;
          off  = seen_count - SEEN_W'(len);
          addr = base_addr + (ADDR_W'(off) & OFFSET_MASK);
          if (reported != 16'hFFFF) reported = reported + 1'b1;
          if (match_limit != 0 && reported >= match_limit) stopped = 1'b1;
        end
      end
      if (hit || last) begin
        res.is_match      = hit;
        res.match_address = addr;
        res.scan_done     = last;
        res.match_total   = reported;
        due_results = {due_results, res};
      end
      if (last) clear_region();
    endfunction

    function void compare_result(scan_result_t got);
      scan_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: match=%0b addr=%h done=%0b total=%0d",
                   got.is_match, got.match_address, got.scan_done, got.match_total);
      end else begin
        want = due_results.pop_front();
        if (want.is_match !== got.is_match || want.match_address !== got.match_address ||
            want.scan_done !== got.scan_done || want.match_total !== got.match_total) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected match=%0b addr=%h done=%0b total=%0d",
                     want.is_match, want.match_address, want.scan_done, want.match_total,
                     " got match=%0b addr=%h done=%0b total=%0d",
                     got.is_match, got.match_address, got.scan_done, got.match_total);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic [7:0]            data_byte_i     = 8'h00;
  logic                  end_of_region_i = 1'b0;
  logic                  out_stall_i     = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  is_match_o;
  logic [ADDR_W-1:0]     match_address_o;
  logic                  scan_done_o;
  logic [COUNT_W-1:0]    match_total_o;
  logic                  cfg_ready_o;

  scan_scoreboard sb;
  scan_result_t   result_in;
  int             idle_pct  = 0;   // chance in a hundred that the sender idles a cycle
  int             stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
  int unsigned    cycle_count = 0;

  masked_byte_pattern_scanner_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_region_i (end_of_region_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_match_o      (is_match_o),
    .match_address_o (match_address_o),
    .scan_done_o     (scan_done_o),
    .match_total_o   (match_total_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: take a result request whenever valid is up and we are not
  // stalling, then pick the stall for the next cycle. Outputs are sampled
  // at the edge, before the block's own updates of this step land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_in.is_match      = is_match_o;
      result_in.match_address = match_address_o;
      result_in.scan_done     = scan_done_o;
      result_in.match_total   = match_total_o;
      sb.compare_result(result_in);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: drop out of the run if it never completes.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic set_mode(input int mode);
    case (mode)
      1:       begin idle_pct = 87; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 87; end
      3:       begin idle_pct = 11; stall_pct = 11; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Offer one byte request and hold it until the block takes it. Valid is
  // dropped only when a gap precedes this byte, so a back-to-back byte
  // keeps valid high across the edge.
  task automatic push_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = 0;
    while (gap < 100 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= data;
    end_of_region_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(data, last);
  endtask

  // Hold a register write request until ready; valid stays up for a
  // following write and is dropped by cfg_release.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, value);
  endtask

  task automatic cfg_release();
    cfg_valid_i <= 1'b0;
  endtask

  // Idle the sender, wait for every predicted result, then let bytes that
  // raise no result drain out of the pipeline.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] junk;
    logic [15:0]           care;
    logic [LEN_W-1:0]      len;
    logic [COUNT_W-1:0]    limit;
    logic [ADDR_W-1:0]     base;
    int                    sel;
    junk = {$urandom, $urandom};
    cfg_write(CFG_PATTERN_LOW,  {$urandom, $urandom});
    cfg_write(CFG_PATTERN_HIGH, {$urandom, $urandom});
    case ($urandom_range(3))
      0:       care = 16'hFFFF;
      1:       care = 16'($urandom);
      2:       care = 16'($urandom | $urandom);
      default: care = 16'h0000;
    endcase
    cfg_write(CFG_CARE_MASK, {junk[63:16], care});
    // mostly short patterns, now and then a longer one up to the longest, or an out-of-range one
    sel = $urandom_range(9);
    if (sel < 6)       len = LEN_W'($urandom_range(1, 4));
    else if (sel < 8)  len = LEN_W'($urandom_range(5, 16));
    else if (sel == 8) len = 5'd0;
    else               len = LEN_W'($urandom_range(17, 31));
    cfg_write(CFG_PATTERN_LEN, {junk[63:5], len});
    sel = $urandom_range(9);
    if (sel < 5)      limit = '0;
    else if (sel < 9) limit = COUNT_W'($urandom_range(1, 3));
    else              limit = COUNT_W'($urandom);
    cfg_write(CFG_MAX_MATCHES, {junk[63:16], limit});
    if ($urandom_range(3) == 0) base = ~64'h0 - $urandom_range(40);
    else                        base = {$urandom, $urandom};
    cfg_write(CFG_BASE_ADDR, base);
    if ($urandom_range(3) == 0)
      cfg_write($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});
    cfg_release();
  endtask

  // Build one region: random or pattern-flavoured noise, with copies of the
  // pattern written in (some cut short, some ending on the last byte).
  task automatic send_region(input int unsigned n);
    logic [7:0]  region_bytes [$];
    int unsigned plen, pos, cut, i, k;
    plen = sb.used_len();
    for (i = 0; i < n; i++)
      region_bytes = {region_bytes,
                      $urandom_range(1) ? 8'($urandom) : sb.pattern[4'($urandom_range(15))]};
    if (n >= plen && $urandom_range(3) != 0) begin
      repeat ($urandom_range(1, 1 + n / (2 * plen))) begin
        pos = $urandom_range(n - plen);
        if ($urandom_range(4) == 0) pos = n - plen;
        cut = plen;
        if ($urandom_range(5) == 0) cut = $urandom_range(plen - 1);
        for (k = 0; k < cut; k++)
          if (sb.care[k]) region_bytes[pos + k] = sb.pattern[k];
      end
    end
    for (i = 0; i < n; i++) push_byte(region_bytes[i], i == n - 1);
  endtask

  task automatic long_region(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
  endtask

  initial begin
    int phase, sent, n, i;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(0);

    // Register defaults: one-byte pattern of zero, every byte compared.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // Three-byte pattern with a wildcard in the middle and a base at the
    // top of the address space; junk in the upper care bits must be ignored.
    cfg_write(CFG_PATTERN_LOW, 64'h0000_0000_0081_7EFF);
    cfg_write(CFG_CARE_MASK, 64'hFFFF_FFFF_FFFF_FFFD);
    cfg_write(CFG_PATTERN_LEN, 64'd3);
    cfg_write(CFG_BASE_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_release();
    push_byte(8'hFF, 1'b1);                 // region shorter than the pattern
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h81, 1'b1);                 // match ends on the last byte, address wraps
    settle();

    // Limit of one match per region.
    cfg_write(CFG_PATTERN_LOW, '1);
    cfg_write(CFG_PATTERN_LEN, 64'd1);
    cfg_write(CFG_MAX_MATCHES, 64'd1);
    cfg_release();
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // Length zero acts as one; match and done share a result.
    cfg_write(CFG_PATTERN_LEN, 64'd0);
    cfg_write(CFG_MAX_MATCHES, 64'd0);
    cfg_release();
    push_byte(8'hFF, 1'b1);
    settle();

    // Length above range acts as the full sixteen bytes.
    cfg_write(CFG_PATTERN_HIGH, 64'h0123_4567_89AB_CDEF);
    cfg_write(CFG_CARE_MASK, 64'hFFFF);
    cfg_write(CFG_PATTERN_LEN, 64'd31);
    cfg_write(CFG_BASE_ADDR, 64'h8000_0000_0000_0000);
    cfg_release();
    for (i = 0; i < 16; i++) push_byte(sb.pattern[i], i == 15);
    settle();

    // Random phases, cycling through the idle and stall patterns.
    for (phase = 0; phase < PHASES; phase++) begin
      random_setup();
      set_mode(phase % 4);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        send_region(n);
        sent += n;
      end
      settle();
    end

    // Every byte matches: first with no limit, then with a limit at the top
    // of its range.
    set_mode(0);
    cfg_write(CFG_CARE_MASK, 64'h0);
    cfg_write(CFG_PATTERN_LEN, 64'd1);
    cfg_write(CFG_MAX_MATCHES, 64'd0);
    cfg_write(CFG_BASE_ADDR, 64'h0);
    cfg_release();
    long_region(24);
    settle();
    cfg_write(CFG_MAX_MATCHES, 64'hFFFF);
    cfg_release();
    long_region(24);
    settle();

    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* masked_byte_pattern_scanner_top.f */
rtl/core/mbps_pkg.sv
rtl/core/mbps_cfg_regs.sv
rtl/core/mbps_window.sv
rtl/core/mbps_tracker.sv
rtl/core/masked_byte_pattern_scanner_top.sv
test/masked_byte_pattern_scanner_top_tb.sv
